>>> rtl/core/pipr_pkg.sv
// shared types and constants of the pruned index permutation remap core
`timescale 1ns / 1ps
`default_nettype none

package pipr_pkg;

   localparam int FIELD_W   = 6;
   localparam int COUNT_W   = 7;
   localparam int MODE_W    = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 7;

   typedef enum logic [MODE_W-1:0] {
      MODE_IDENTITY = 2'd0,
      MODE_GRAY     = 2'd1,
      MODE_REVERSE  = 2'd2,
      MODE_UNUSED   = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE  = 1'b0,
      CSR_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_BUILD = 2'b10
   } state_type;

endpackage

`default_nettype wire

>>> rtl/core/pruned_index_permutation_remap_core.sv
// pruned index permutation remap core: table build and dual-port lookup
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+--------------------------
//  request | req_two_qubit, req_target_index,        | start && !busy
//          | req_control_index                       |
//  result  | rsp_mapped_target, rsp_mapped_control   | rsp_valid
//  csr     | csr_index, csr_wdata                    | csr_valid && csr_ready
//
// a result word shows in the cycle after its request is taken; one request per cycle while not busy
// every csr write starts a table build that walks 2^k sequence values, k = ceil(log2(N)),
// at most 2^ceil(log2(MAX_INDICES)), through the single write port of the table
// during a build busy is high and csr_ready is low
// reset gives identity mode with N = 1; the table is undefined until first built
// the result side has no stall
`timescale 1ns / 1ps
`default_nettype none

module pruned_index_permutation_remap_core #(
   parameter int MAX_INDICES = 64
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   output logic                                busy,
   input  wire                                 req_two_qubit,
   input  wire  [pipr_pkg::FIELD_W-1:0]        req_target_index,
   input  wire  [pipr_pkg::FIELD_W-1:0]        req_control_index,
   output logic                                rsp_valid,
   output logic [pipr_pkg::FIELD_W-1:0]        rsp_mapped_target,
   output logic [pipr_pkg::FIELD_W-1:0]        rsp_mapped_control,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [pipr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [pipr_pkg::CSR_DAT_W-1:0]      csr_wdata
);

   localparam int AW = (MAX_INDICES > 1) ? $clog2(MAX_INDICES) : 1;
   localparam int NW = (AW + 1 > pipr_pkg::COUNT_W) ? AW + 1 : pipr_pkg::COUNT_W;
   localparam int KW = $clog2(AW + 1);
   localparam int FW = pipr_pkg::FIELD_W;

   // configuration
   pipr_pkg::mode_type              mode_ff;
   logic [pipr_pkg::COUNT_W-1:0]    count_ff;
   logic [NW-1:0]                   count_ext;
   logic [NW-1:0]                   n_sat;
   logic                            mode_ok;

   // build sequencer
   pipr_pkg::state_type             state_ff, state_in;
   logic [AW-1:0]                   seq_ff, seq_in;
   logic [AW-1:0]                   seen_ff, seen_in;
   logic [KW-1:0]                   k_bits;
   logic [AW-1:0]                   seq_last;
   logic [AW-1:0]                   rev_full;
   logic [AW-1:0]                   seq_val;
   logic [KW-1:0]                   rev_shift;
   logic                            val_ok;

   // permutation table
   logic [AW-1:0]                   perm_mem [MAX_INDICES];

   // lookup stage
   logic                            accept;
   logic [NW-1:0]                   tgt_ext, ctl_ext;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            pass_t_ff, pass_c_ff;
   logic [FW-1:0]                   tgt_ff, ctl_ff;
   logic [AW-1:0]                   t_rd_ff, c_rd_ff;
   logic [NW-1:0]                   t_wide, c_wide;
   logic                            csr_write;

   assign count_ext = NW'(count_ff);
   assign n_sat     = (count_ext > NW'(MAX_INDICES)) ? NW'(MAX_INDICES) : count_ext;
   assign mode_ok   = (mode_ff == pipr_pkg::MODE_GRAY) || (mode_ff == pipr_pkg::MODE_REVERSE);

   assign busy      = (state_ff == pipr_pkg::ST_BUILD);
   assign csr_ready = (state_ff == pipr_pkg::ST_IDLE);
   assign csr_write = csr_valid && csr_ready;
   assign accept    = start && !busy;

   // k = number of powers of two below n
   always_comb begin
      k_bits = '0;
      for (int j = 0; j < AW; j++) begin
         if ((NW'(1) << j) < n_sat) begin
            k_bits = k_bits + KW'(1);
         end
      end
   end

   assign seq_last = AW'((NW'(1) << k_bits) - NW'(1));

   always_comb begin
      for (int b = 0; b < AW; b++) begin
         rev_full[AW-1-b] = seq_ff[b];
      end
   end

   assign rev_shift = KW'(AW) - k_bits;

   always_comb begin
      case (mode_ff)
         pipr_pkg::MODE_REVERSE: begin
            seq_val = rev_full >> rev_shift;
         end
         default: begin
            seq_val = seq_ff ^ (seq_ff >> 1);
         end
      endcase
   end

   assign val_ok = (NW'(seq_val) < n_sat);

   always_comb begin
      state_in = state_ff;
      seq_in   = seq_ff;
      seen_in  = seen_ff;
      case (state_ff)
         pipr_pkg::ST_IDLE: begin
            if (csr_write) begin
               state_in = pipr_pkg::ST_BUILD;
               seq_in   = '0;
               seen_in  = '0;
            end
         end
         pipr_pkg::ST_BUILD: begin
            seq_in = seq_ff + AW'(1);
            if (val_ok) begin
               seen_in = seen_ff + AW'(1);
            end
            if (seq_ff == seq_last) begin
               state_in = pipr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pipr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pipr_pkg::ST_IDLE;
         mode_ff  <= pipr_pkg::MODE_IDENTITY;
         count_ff <= pipr_pkg::COUNT_W'(1);
         seq_ff   <= '0;
         seen_ff  <= '0;
      end else begin
         state_ff <= state_in;
         seq_ff   <= seq_in;
         seen_ff  <= seen_in;
         if (csr_write) begin
            case (csr_index)
               pipr_pkg::CSR_MODE: begin
                  mode_ff <= pipr_pkg::mode_type'(csr_wdata[pipr_pkg::MODE_W-1:0]);
               end
               pipr_pkg::CSR_COUNT: begin
                  count_ff <= csr_wdata[pipr_pkg::COUNT_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // table write during build, two registered reads on request
   assign tgt_ext = NW'(req_target_index);
   assign ctl_ext = NW'(req_control_index);

   always_ff @(posedge clock) begin
      if (busy && val_ok) begin
         perm_mem[seen_ff] <= seq_val;
      end
      if (accept) begin
         t_rd_ff <= perm_mem[tgt_ext[AW-1:0]];
         c_rd_ff <= perm_mem[ctl_ext[AW-1:0]];
      end
   end

   assign rsp_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tgt_ff    <= req_target_index;
         ctl_ff    <= req_control_index;
         pass_t_ff <= !mode_ok || (tgt_ext >= n_sat);
         // single gates keep their control word
         pass_c_ff <= !mode_ok || (ctl_ext >= n_sat) || !req_two_qubit;
      end
   end

   assign t_wide = NW'(t_rd_ff);
   assign c_wide = NW'(c_rd_ff);

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mapped_target  = pass_t_ff ? tgt_ff : t_wide[FW-1:0];
   assign rsp_mapped_control = pass_c_ff ? ctl_ff : c_wide[FW-1:0];

endmodule

`default_nettype wire

>>> rtl/core/pipr_checker.sv
// port-level checker for the remap core, bound to the core module
`timescale 1ns / 1ps
`default_nettype none

module pipr_checker (
   input wire                               clock,
   input wire                               reset,
   input wire                               start,
   input wire                               busy,
   input wire                               req_two_qubit,
   input wire [pipr_pkg::FIELD_W-1:0]       req_control_index,
   input wire                               rsp_valid,
   input wire [pipr_pkg::FIELD_W-1:0]       rsp_mapped_control,
   input wire                               csr_valid,
   input wire                               csr_ready
);

   // every word answers a request taken in the previous cycle
   a_rsp_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy))
      else $error("result word without a request");

   a_request_answered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("request not answered in the next cycle");

   a_csr_rebuilds: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> busy)
      else $error("csr write did not start a table build");

   a_no_csr_in_build: assert property (@(posedge clock) disable iff (reset)
      busy |-> !csr_ready)
      else $error("csr port open during table build");

   a_single_ctl_kept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(req_two_qubit)) |-> rsp_mapped_control == $past(req_control_index))
      else $error("single gate control word changed");

endmodule

bind pruned_index_permutation_remap_core pipr_checker u_pipr_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_two_qubit      (req_two_qubit),
   .req_control_index  (req_control_index),
   .rsp_valid          (rsp_valid),
   .rsp_mapped_control (rsp_mapped_control),
   .csr_valid          (csr_valid),
   .csr_ready          (csr_ready)
);

`default_nettype wire

>>> sim/testbench.sv
// self-checking testbench for the pruned index permutation remap core
`timescale 1ns / 1ps

module testbench;

   localparam int MAX_INDICES  = 64;
   localparam int NUM_RANDOM   = 450;
   localparam int CALM_TAIL    = 60;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int FW           = pipr_pkg::FIELD_W;
   localparam int DW           = pipr_pkg::CSR_DAT_W;
   localparam int CW           = pipr_pkg::COUNT_W;
   localparam int MW           = pipr_pkg::MODE_W;

   localparam logic [DW-1:0] DAT_IDENTITY = DW'(pipr_pkg::MODE_IDENTITY);
   localparam logic [DW-1:0] DAT_GRAY     = DW'(pipr_pkg::MODE_GRAY);
   localparam logic [DW-1:0] DAT_REVERSE  = DW'(pipr_pkg::MODE_REVERSE);

   typedef struct packed {
      logic [FW-1:0] target;
      logic [FW-1:0] control;
   } remap_word_type;

   typedef struct {
      bit                      is_csr;
      pipr_pkg::csr_index_type reg_index;
      logic [DW-1:0]           reg_data;
      logic                    two_qubit;
      logic [FW-1:0]           target;
      logic [FW-1:0]           control;
      bit                      known;
      remap_word_type          known_word;
   } stim_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic                    req_two_qubit = 1'b0;
   logic [FW-1:0]           req_target_index = '0;
   logic [FW-1:0]           req_control_index = '0;
   logic                    rsp_valid;
   logic [FW-1:0]           rsp_mapped_target;
   logic [FW-1:0]           rsp_mapped_control;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   pipr_pkg::csr_index_type csr_index = pipr_pkg::CSR_MODE;
   logic [DW-1:0]           csr_wdata = '0;

   pipr_pkg::mode_type      cur_mode = pipr_pkg::MODE_IDENTITY;
   logic [CW-1:0]           cur_count = 7'd1;
   remap_word_type          pending_remaps[$];
   stim_row_type            directed_rows[$];
   int                      mismatch_count = 0;
   int                      cycle_count = 0;

   pruned_index_permutation_remap_core #(
      .MAX_INDICES(MAX_INDICES)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_two_qubit      (req_two_qubit),
      .req_target_index   (req_target_index),
      .req_control_index  (req_control_index),
      .rsp_valid          (rsp_valid),
      .rsp_mapped_target  (rsp_mapped_target),
      .rsp_mapped_control (rsp_mapped_control),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // x-th value below n of the k-bit gray or bit-reversed sequence
   function automatic logic [FW-1:0] permuted_index(pipr_pkg::mode_type mode,
                                                     logic [CW-1:0] count,
                                                     logic [FW-1:0] x);
      int n;
      int k;
      int span;
      int seen;
      int v;
      int i;
      int b;
      n = (int'(count) > MAX_INDICES) ? MAX_INDICES : int'(count);
      if ((mode != pipr_pkg::MODE_GRAY && mode != pipr_pkg::MODE_REVERSE) || x >= n)
         return x;
      k = 0;
      while ((1 << k) < n)
         k++;
      span = 1 << k;
      seen = 0;
      for (i = 0; i < span; i++) begin
         if (mode == pipr_pkg::MODE_GRAY) begin
            v = i ^ (i >> 1);
         end else begin
            v = 0;
            for (b = 0; b < k; b++)
               if (((i >> b) & 1) != 0)
                  v = v | (1 << (k - 1 - b));
         end
         if (v < n) begin
            if (seen == x)
               return v[FW-1:0];
            seen++;
         end
      end
      return x;
   endfunction

   function automatic remap_word_type predicted_word(logic two, logic [FW-1:0] tgt,
                                                     logic [FW-1:0] ctl);
      remap_word_type w;
      w.target  = permuted_index(cur_mode, cur_count, tgt);
      w.control = two ? permuted_index(cur_mode, cur_count, ctl) : ctl;
      return w;
   endfunction

   function automatic stim_row_type blank_row();
      stim_row_type r;
      r.is_csr     = 1'b0;
      r.reg_index  = pipr_pkg::CSR_MODE;
      r.reg_data   = '0;
      r.two_qubit  = 1'b0;
      r.target     = '0;
      r.control    = '0;
      r.known      = 1'b0;
      r.known_word = '0;
      return r;
   endfunction

   function automatic stim_row_type csr_row(pipr_pkg::csr_index_type idx,
                                            logic [DW-1:0] data);
      stim_row_type r;
      r = blank_row();
      r.is_csr    = 1'b1;
      r.reg_index = idx;
      r.reg_data  = data;
      return r;
   endfunction

   function automatic stim_row_type gate_row(logic two, logic [FW-1:0] tgt,
                                             logic [FW-1:0] ctl);
      stim_row_type r;
      r = blank_row();
      r.two_qubit = two;
      r.target    = tgt;
      r.control   = ctl;
      return r;
   endfunction

   function automatic stim_row_type known_row(logic two, logic [FW-1:0] tgt,
                                              logic [FW-1:0] ctl,
                                              logic [FW-1:0] want_tgt,
                                              logic [FW-1:0] want_ctl);
      stim_row_type r;
      r = gate_row(two, tgt, ctl);
      r.known              = 1'b1;
      r.known_word.target  = want_tgt;
      r.known_word.control = want_ctl;
      return r;
   endfunction

   function automatic void add_row(stim_row_type r);
      directed_rows.insert(directed_rows.size(), r);
   endfunction

   // drop start and let every outstanding word come back
   task automatic drain();
      start <= 1'b0;
      do
         @(posedge clock);
      while (pending_remaps.size() != 0);
   endtask

   task automatic write_csr(pipr_pkg::csr_index_type idx, logic [DW-1:0] data);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == pipr_pkg::CSR_MODE)
         cur_mode = pipr_pkg::mode_type'(data[MW-1:0]);
      else
         cur_count = data;
   endtask

   // leaves start high so back-to-back words need no extra step
   task automatic send_gate(logic two, logic [FW-1:0] tgt, logic [FW-1:0] ctl,
                            bit known, remap_word_type known_word);
      start             <= 1'b1;
      req_two_qubit     <= two;
      req_target_index  <= tgt;
      req_control_index <= ctl;
      do
         @(posedge clock);
      while (busy);
      if (known)
         pending_remaps.insert(pending_remaps.size(), known_word);
      else
         pending_remaps.insert(pending_remaps.size(), predicted_word(two, tgt, ctl));
   endtask

   always @(posedge clock) begin
      remap_word_type want;
      if (!reset && rsp_valid) begin
         if (pending_remaps.size() == 0) begin
            $error("result word with no request outstanding");
            mismatch_count++;
         end else begin
            want = pending_remaps.pop_front();
            if (rsp_mapped_target !== want.target) begin
               $error("mapped_target: expected %0d, got %0d", want.target, rsp_mapped_target);
               mismatch_count++;
            end
            if (rsp_mapped_control !== want.control) begin
               $error("mapped_control: expected %0d, got %0d", want.control,
                      rsp_mapped_control);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      stim_row_type         row;
      remap_word_type       none;
      int                   sent;
      int                   phase;
      int                   burst;
      int                   j;
      int                   n;
      logic                 two;
      logic [FW-1:0]        tgt;
      logic [FW-1:0]        ctl;
      logic [DW-1:0]        data;

      none = '0;

      // identity with one index, written once so the table gets built
      add_row(csr_row(pipr_pkg::CSR_MODE, DAT_IDENTITY));
      add_row(known_row(1'b0, 6'd0, 6'd63, 6'd0, 6'd63));
      add_row(known_row(1'b1, 6'd63, 6'd63, 6'd63, 6'd63));
      add_row(known_row(1'b1, 6'd0, 6'd0, 6'd0, 6'd0));
      add_row(csr_row(pipr_pkg::CSR_COUNT, 7'd64));
      add_row(csr_row(pipr_pkg::CSR_MODE, DAT_GRAY));
      add_row(known_row(1'b1, 6'd0, 6'd63, 6'd0, 6'd32));
      add_row(gate_row(1'b0, 6'd42, 6'd21));
      add_row(gate_row(1'b1, 6'd21, 6'd42));
      add_row(csr_row(pipr_pkg::CSR_MODE, DAT_REVERSE));
      add_row(known_row(1'b1, 6'd1, 6'd62, 6'd32, 6'd31));
      add_row(known_row(1'b1, 6'd63, 6'd0, 6'd63, 6'd0));
      // empty domain: everything passes through
      add_row(csr_row(pipr_pkg::CSR_COUNT, 7'd0));
      add_row(known_row(1'b1, 6'd5, 6'd7, 6'd5, 6'd7));
      add_row(known_row(1'b1, 6'd0, 6'd63, 6'd0, 6'd63));
      // count above the table size saturates
      add_row(csr_row(pipr_pkg::CSR_COUNT, 7'd127));
      add_row(known_row(1'b1, 6'd1, 6'd62, 6'd32, 6'd31));
      add_row(known_row(1'b0, 6'd63, 6'd0, 6'd63, 6'd0));
      // unused mode with the upper data bits set acts as identity
      add_row(csr_row(pipr_pkg::CSR_MODE, 7'h7f));
      add_row(known_row(1'b1, 6'd13, 6'd50, 6'd13, 6'd50));
      add_row(csr_row(pipr_pkg::CSR_COUNT, 7'd5));
      add_row(csr_row(pipr_pkg::CSR_MODE, DAT_GRAY));
      add_row(gate_row(1'b1, 6'd3, 6'd4));
      add_row(gate_row(1'b1, 6'd5, 6'd1));
      add_row(gate_row(1'b0, 6'd4, 6'd60));
      add_row(csr_row(pipr_pkg::CSR_MODE, DAT_REVERSE));
      add_row(gate_row(1'b1, 6'd2, 6'd4));
      add_row(gate_row(1'b1, 6'd0, 6'd1));
      add_row(csr_row(pipr_pkg::CSR_COUNT, 7'd2));
      add_row(gate_row(1'b1, 6'd0, 6'd1));
      add_row(gate_row(1'b1, 6'd1, 6'd2));
      add_row(csr_row(pipr_pkg::CSR_COUNT, 7'd63));
      add_row(gate_row(1'b1, 6'd62, 6'd31));
      add_row(gate_row(1'b0, 6'd32, 6'd17));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_csr)
            write_csr(row.reg_index, row.reg_data);
         else
            send_gate(row.two_qubit, row.target, row.control, row.known, row.known_word);
      end

      sent  = 0;
      phase = 0;
      while (sent < NUM_RANDOM) begin
         if ($urandom_range(0, 3) != 0) begin
            data = DW'($urandom);
            data[MW-1:0] = MW'($urandom_range(0, 3));
            write_csr(pipr_pkg::CSR_MODE, data);
         end
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
               0: data = 7'd0;
               1: data = 7'd64;
               2: data = DW'($urandom_range(65, 127));
               default: data = DW'($urandom_range(1, 63));
            endcase
            write_csr(pipr_pkg::CSR_COUNT, data);
         end
         n = (int'(cur_count) > MAX_INDICES) ? MAX_INDICES : int'(cur_count);
         burst = int'($urandom_range(20, 40));
         for (j = 0; j < burst && sent < NUM_RANDOM; j++) begin
            if (j == burst / 2 && (phase == 1 || $urandom_range(0, 5) == 0))
               drain();
            two = 1'($urandom_range(0, 1));
            // mostly in-domain indices so the table is exercised
            if (n != 0 && $urandom_range(0, 7) != 0)
               tgt = FW'($urandom_range(0, n - 1));
            else
               tgt = FW'($urandom_range(0, 63));
            if (n != 0 && $urandom_range(0, 7) != 0)
               ctl = FW'($urandom_range(0, n - 1));
            else
               ctl = FW'($urandom_range(0, 63));
            send_gate(two, tgt, ctl, 1'b0, none);
            sent++;
            if (sent < NUM_RANDOM - CALM_TAIL && $urandom_range(0, 3) == 0) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 5)) @(posedge clock);
            end
         end
         phase++;
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_remaps.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
